@@ rtl/lls_pkg.sv @@
`timescale 1ns / 1ps
// lls_pkg: shared widths, operation and status codes, and the scan carry
// record of the least-loaded server selector. No dependencies.
package lls_pkg;

  localparam int LLS_SLOTS       = 16;
  localparam int LLS_ID_W        = 8;
  localparam int LLS_ADDR_W      = 32;
  localparam int LLS_PORT_W      = 16;
  localparam int LLS_LOAD_W      = 16;
  localparam int LLS_HANDLE_W    = 16;
  localparam int LLS_TIME_W      = 48;
  localparam int LLS_TIMEOUT_W   = 22;
  localparam int LLS_COUNT_W     = 9;
  localparam int LLS_STATUS_W    = 3;
  localparam int LLS_OP_W        = 2;

  localparam logic [LLS_TIMEOUT_W-1:0] LLS_TIMEOUT_RESET = 22'd30000;

  // operation codes
  localparam logic [LLS_OP_W-1:0] OP_REPORT  = 2'd0;
  localparam logic [LLS_OP_W-1:0] OP_REQUEST = 2'd1;
  localparam logic [LLS_OP_W-1:0] OP_TICK    = 2'd2;
  localparam logic [LLS_OP_W-1:0] OP_NONE    = 2'd3;

  // result status codes
  localparam logic [LLS_STATUS_W-1:0] ST_ASSIGNED  = 3'd0;
  localparam logic [LLS_STATUS_W-1:0] ST_NO_SERVER = 3'd1;
  localparam logic [LLS_STATUS_W-1:0] ST_STORED    = 3'd2;
  localparam logic [LLS_STATUS_W-1:0] ST_DROPPED   = 3'd3;
  localparam logic [LLS_STATUS_W-1:0] ST_TICK      = 3'd4;

  // record that walks the slot chain, one cell per cycle
  typedef struct packed {
    logic                    active;
    logic                    hit;
    logic                    free_seen;
    logic                    best;
    logic [LLS_LOAD_W-1:0]   best_load;
    logic [LLS_ID_W-1:0]     best_id;
    logic [LLS_ADDR_W-1:0]   best_addr;
    logic [LLS_PORT_W-1:0]   best_port;
    logic [LLS_COUNT_W-1:0]  count;
  } lls_carry_t;

endpackage

@@ rtl/least_loaded_server_selector.sv @@
`timescale 1ns / 1ps
// least_loaded_server_selector: top level; input capture, chain of slot
// cells, result register. Depends on lls_pkg and lls_cell.
//
// Usage:
//   in_* channel: one transaction per operation (op 0 report, 1 request,
//   2 tick). op 3 is taken and dropped without a result.
//   out_* channel: one result transaction per report, request or tick.
//   cfg_* channel: writes the server timeout; always ready, write only
//   while no operation is in flight.
// Scan: a record walks the row of SLOTS cells one cell per cycle; at the
// end of the row it is registered in tail_r, and the result is then
// registered in the output register. One operation at a time: a new one is
// taken only once the previous result has entered the output register.
// A report that misses every slot is inserted into the first free slot in
// the cycle the record leaves the chain.
// Reset: all slots invalid, timeout back to 30000, no result pending.
// Stall: a finished result waits in the output register while in_ready is
// high again; if a second result finishes before the first is taken it is
// held until the output register frees.
module least_loaded_server_selector import lls_pkg::*; #(
  parameter int SLOTS = LLS_SLOTS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [LLS_OP_W-1:0]      in_op,
  input  logic [LLS_ID_W-1:0]      in_server_id,
  input  logic [LLS_ADDR_W-1:0]    in_server_address,
  input  logic [LLS_PORT_W-1:0]    in_server_port,
  input  logic [LLS_LOAD_W-1:0]    in_server_load,
  input  logic [LLS_HANDLE_W-1:0]  in_requester,
  input  logic [LLS_TIME_W-1:0]    in_now_ms,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [LLS_STATUS_W-1:0]  out_status,
  output logic [LLS_HANDLE_W-1:0]  out_client_handle,
  output logic [LLS_ID_W-1:0]      out_chosen_id,
  output logic [LLS_ADDR_W-1:0]    out_chosen_address,
  output logic [LLS_PORT_W-1:0]    out_chosen_port,
  output logic [LLS_COUNT_W-1:0]   out_expired_count,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [LLS_TIMEOUT_W-1:0] cfg_data
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]               state_r, state_nxt;
  logic [LLS_TIMEOUT_W-1:0] timeout_r;
  logic [LLS_OP_W-1:0]      op_r;
  logic [LLS_ID_W-1:0]      id_r;
  logic [LLS_ADDR_W-1:0]    addr_r;
  logic [LLS_PORT_W-1:0]    port_r;
  logic [LLS_LOAD_W-1:0]    load_r;
  logic [LLS_HANDLE_W-1:0]  req_r;
  logic [LLS_TIME_W-1:0]    now_r;
  lls_carry_t               head_r, head_nxt;
  lls_carry_t               tail_r;
  lls_carry_t               chain [SLOTS+1];
  logic                     in_fire, tail_done, commit, out_free;
  logic                     out_valid_r, out_valid_nxt;
  logic [LLS_STATUS_W-1:0]  res_status;
  logic [LLS_HANDLE_W-1:0]  res_handle;
  logic [LLS_ID_W-1:0]      res_id;
  logic [LLS_ADDR_W-1:0]    res_addr;
  logic [LLS_PORT_W-1:0]    res_port;
  logic [LLS_COUNT_W-1:0]   res_count;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready && (in_op != OP_NONE);
  assign tail_done = (state_r == S_SCAN) && chain[SLOTS].active;
  assign out_free  = !out_valid_r || out_ready;

  // insert into the claimed free slot when no slot matched the id
  assign commit = tail_done && (op_r == OP_REPORT) &&
                  !chain[SLOTS].hit && chain[SLOTS].free_seen;

  assign chain[0] = head_r;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    lls_cell u_cell (
      .clk            (clk),
      .rst_n          (rst_n),
      .op             (op_r),
      .server_id      (id_r),
      .server_address (addr_r),
      .server_port    (port_r),
      .server_load    (load_r),
      .now_ms         (now_r),
      .server_timeout (timeout_r),
      .commit         (commit),
      .carry_i        (chain[g]),
      .carry_o        (chain[g+1])
    );
  end

  always_comb begin
    head_nxt = '0;
    if (in_fire) begin
      head_nxt.active = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_fire) state_nxt = S_SCAN;
      S_SCAN: if (tail_done) state_nxt = S_FIN;
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    res_status = ST_TICK;
    res_handle = '0;
    res_id     = '0;
    res_addr   = '0;
    res_port   = '0;
    res_count  = '0;
    case (op_r)
      OP_REPORT: begin
        res_status = (tail_r.hit || tail_r.free_seen) ? ST_STORED : ST_DROPPED;
      end
      OP_REQUEST: begin
        res_handle = req_r;
        if (tail_r.best) begin
          res_status = ST_ASSIGNED;
          res_id     = tail_r.best_id;
          res_addr   = tail_r.best_addr;
          res_port   = tail_r.best_port;
        end else begin
          res_status = ST_NO_SERVER;
        end
      end
      default: begin
        res_count = tail_r.count;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (state_r == S_FIN && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= LLS_TIMEOUT_RESET;
      head_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        timeout_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_r   <= in_op;
      id_r   <= in_server_id;
      addr_r <= in_server_address;
      port_r <= in_server_port;
      load_r <= in_server_load;
      req_r  <= in_requester;
      now_r  <= in_now_ms;
    end
    if (tail_done) begin
      tail_r <= chain[SLOTS];
    end
    if (state_r == S_FIN && out_free) begin
      out_status         <= res_status;
      out_client_handle  <= res_handle;
      out_chosen_id      <= res_id;
      out_chosen_address <= res_addr;
      out_chosen_port    <= res_port;
      out_expired_count  <= res_count;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ rtl/lls_cell.sv @@
`timescale 1ns / 1ps
// lls_cell: one server slot of the chain; updates its entry as the carry
// record passes and hands the record on. Depends on lls_pkg.
module lls_cell import lls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [LLS_OP_W-1:0]      op,
  input  logic [LLS_ID_W-1:0]      server_id,
  input  logic [LLS_ADDR_W-1:0]    server_address,
  input  logic [LLS_PORT_W-1:0]    server_port,
  input  logic [LLS_LOAD_W-1:0]    server_load,
  input  logic [LLS_TIME_W-1:0]    now_ms,
  input  logic [LLS_TIMEOUT_W-1:0] server_timeout,
  input  logic                     commit,
  input  lls_carry_t               carry_i,
  output lls_carry_t               carry_o
);

  logic                    valid_r, valid_nxt;
  logic                    claim_r, claim_nxt;
  logic [LLS_ID_W-1:0]     id_r, id_nxt;
  logic [LLS_ADDR_W-1:0]   addr_r, addr_nxt;
  logic [LLS_PORT_W-1:0]   port_r, port_nxt;
  logic [LLS_LOAD_W-1:0]   load_r, load_nxt;
  logic [LLS_TIME_W-1:0]   seen_r, seen_nxt;
  lls_carry_t              carry_r, carry_nxt;
  logic                    write_en;
  logic                    expired;

  // sum kept one bit wider so it never wraps
  assign expired = {1'b0, now_ms} >
                   ({1'b0, seen_r} + (LLS_TIME_W+1)'(server_timeout));

  always_comb begin
    valid_nxt = valid_r;
    claim_nxt = claim_r;
    carry_nxt = carry_i;
    write_en  = 1'b0;
    if (carry_i.active) begin
      case (op)
        OP_REPORT: begin
          // first free slot on the way remembers it may take the insert
          claim_nxt = !valid_r && !carry_i.free_seen;
          if (!valid_r) begin
            carry_nxt.free_seen = 1'b1;
          end
          if (valid_r && id_r == server_id && !carry_i.hit) begin
            carry_nxt.hit = 1'b1;
            write_en      = 1'b1;
          end
        end
        OP_REQUEST: begin
          if (valid_r && (!carry_i.best || load_r < carry_i.best_load)) begin
            carry_nxt.best      = 1'b1;
            carry_nxt.best_load = load_r;
            carry_nxt.best_id   = id_r;
            carry_nxt.best_addr = addr_r;
            carry_nxt.best_port = port_r;
          end
        end
        OP_TICK: begin
          if (valid_r && expired) begin
            valid_nxt       = 1'b0;
            carry_nxt.count = carry_i.count + LLS_COUNT_W'(1);
          end
        end
        default: ;
      endcase
    end
    if (commit && claim_r) begin
      write_en  = 1'b1;
      valid_nxt = 1'b1;
    end
  end

  always_comb begin
    id_nxt   = id_r;
    addr_nxt = addr_r;
    port_nxt = port_r;
    load_nxt = load_r;
    seen_nxt = seen_r;
    if (write_en) begin
      id_nxt   = server_id;
      addr_nxt = server_address;
      port_nxt = server_port;
      load_nxt = server_load;
      seen_nxt = now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      claim_r <= 1'b0;
      carry_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      claim_r <= claim_nxt;
      carry_r <= carry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    addr_r <= addr_nxt;
    port_r <= port_nxt;
    load_r <= load_nxt;
    seen_r <= seen_nxt;
  end

  assign carry_o = carry_r;

endmodule

@@ rtl/lls_checker.sv @@
`timescale 1ns / 1ps
// lls_checker: port-level assertions for the least-loaded server selector,
// bound to the top level. Depends on lls_pkg.
module lls_checker import lls_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic [LLS_OP_W-1:0]     in_op,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [LLS_STATUS_W-1:0] out_status,
  input logic [LLS_ID_W-1:0]     out_chosen_id,
  input logic [LLS_ADDR_W-1:0]   out_chosen_address,
  input logic [LLS_PORT_W-1:0]   out_chosen_port,
  input logic [LLS_COUNT_W-1:0]  out_expired_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result changed while stalled");

  // one operation at a time: input closes after a real transaction
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_NONE) |=> !in_ready)
    else $error("input accepted while an operation is in flight");

  a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_TICK) |-> out_expired_count == '0)
    else $error("expired count on a non-tick result");

  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ASSIGNED) |->
      out_chosen_id == '0 && out_chosen_address == '0 && out_chosen_port == '0)
    else $error("server fields set on a result without assignment");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind least_loaded_server_selector lls_checker u_lls_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .in_op              (in_op),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_status         (out_status),
  .out_chosen_id      (out_chosen_id),
  .out_chosen_address (out_chosen_address),
  .out_chosen_port    (out_chosen_port),
  .out_expired_count  (out_expired_count)
);
